// ===== src/esort_pkg.sv =====
// Shared beat types and controller-to-datapath command bundle for the exchange sort engine.
`default_nettype none

package esort_pkg;

  localparam int unsigned DataWidth = 32;

  typedef struct packed {
    logic signed [DataWidth-1:0] sample_value;
    logic                        set_end;
  } in_beat_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] sorted_value;
    logic                        run_end;
    logic                        overflowed;
  } out_beat_t;

  typedef struct packed {
    logic load_wr;
    logic hold;
    logic scan;
    logic emit;
    logic emit_last;
    logic emit_ovf;
  } cmd_t;

endpackage

`default_nettype wire

// ===== src/esort_ctrl.sv =====
// Sequencer for the exchange sort engine: load count, outer and inner indexes, command issue.
`default_nettype none

module esort_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  input  wire logic                                in_last_i,
  output logic                                     in_ready_o,
  input  wire logic                                out_free_i,
  output esort_pkg::cmd_t                          cmd_o,
  output logic [$clog2(CAPACITY)-1:0]              rd_addr_o,
  output logic [$clog2(CAPACITY)-1:0]              wr_addr_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_HOLD,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] j_q, j_d;

  logic [CW-1:0] i_nxt;
  logic [CW-1:0] j_nxt;
  logic          fill_full;
  logic          in_accept;

  assign i_nxt      = CW'(i_q) + CW'(1);
  assign j_nxt      = CW'(j_q) + CW'(1);
  assign fill_full  = (fill_q == CW'(CAPACITY));
  assign in_ready_o = (state_q == ST_LOAD);
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    cmd_o     = '0;
    rd_addr_o = i_q;
    wr_addr_o = j_q;
    unique case (state_q)
      ST_LOAD: begin
        wr_addr_o = fill_q[IW-1:0];
        if (in_accept) begin
          if (!fill_full) begin
            cmd_o.load_wr = 1'b1;
            fill_d        = fill_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            i_d     = '0;
            state_d = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        rd_addr_o = i_q;
        state_d   = ST_HOLD;
      end
      ST_HOLD: begin
        cmd_o.hold = 1'b1;
        if (i_nxt < fill_q) begin
          rd_addr_o = i_nxt[IW-1:0];
          j_d       = i_nxt[IW-1:0];
          state_d   = ST_SCAN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        wr_addr_o  = j_q;
        if (j_nxt < fill_q) begin
          rd_addr_o = j_nxt[IW-1:0];
          j_d       = j_nxt[IW-1:0];
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = (i_nxt == fill_q);
          cmd_o.emit_ovf  = ovf_q;
          if (i_nxt == fill_q) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            rd_addr_o = i_nxt[IW-1:0];
            i_d       = i_nxt[IW-1:0];
            state_d   = ST_HOLD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/esort_dpath.sv =====
// Datapath for the exchange sort engine: value memory, running minimum, compare-swap, output register.
`default_nettype none

module esort_dpath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic signed [esort_pkg::DataWidth-1:0] sample_i,
  input  wire esort_pkg::cmd_t                     cmd_i,
  input  wire logic [$clog2(CAPACITY)-1:0]         rd_addr_i,
  input  wire logic [$clog2(CAPACITY)-1:0]         wr_addr_i,
  output logic                                     out_free_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output esort_pkg::out_beat_t                     out_beat_o
);

  localparam int unsigned DW = esort_pkg::DataWidth;

  logic signed [DW-1:0] mem [CAPACITY];
  logic signed [DW-1:0] rdata_q;
  logic signed [DW-1:0] cur_q, cur_d;
  logic                 greater;
  logic                 wr_en;
  logic signed [DW-1:0] wr_data;

  logic                 out_valid_q;
  esort_pkg::out_beat_t out_beat_q;

  assign greater = (cur_q > rdata_q);
  assign wr_en   = cmd_i.load_wr || (cmd_i.scan && greater);
  assign wr_data = cmd_i.load_wr ? sample_i : cur_q;

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.hold || (cmd_i.scan && greater)) begin
      cur_d = rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr_i] <= wr_data;
    end
    rdata_q <= mem[rd_addr_i];
    cur_q   <= cur_d;
  end

  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_beat_q.sorted_value <= cur_q;
      out_beat_q.run_end      <= cmd_i.emit_last;
      out_beat_q.overflowed   <= cmd_i.emit_ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

endmodule

`default_nettype wire

// ===== src/exchange_sort_engine.sv =====
// Top level of the exchange sort engine: loads a set, sorts it ascending, streams the run out.
//
//   channel  direction  handshake               beat
//   in       input      in_valid_i/in_ready_o   esort_pkg::in_beat_t
//   out      output     out_valid_o/out_ready_i esort_pkg::out_beat_t
//
// Loading accepts one value per cycle; the set-closing beat starts the sort.
// The stored set is then sorted and streamed out before the next set can load;
// each inner scan does one read-compare-write per memory cycle.
// Each sorted value waits in the output register; a stalled output holds the sort.
// Reset clears state, load count, overflow flag, indexes and output valid only.
`default_nettype none

module exchange_sort_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire esort_pkg::in_beat_t  in_beat_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output esort_pkg::out_beat_t      out_beat_o
);

  localparam int unsigned IW = $clog2(CAPACITY);

  esort_pkg::cmd_t cmd;
  logic [IW-1:0]   rd_addr;
  logic [IW-1:0]   wr_addr;
  logic            out_free;

  esort_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_beat_i.set_end),
    .in_ready_o (in_ready_o),
    .out_free_i (out_free),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr),
    .wr_addr_o  (wr_addr)
  );

  esort_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (in_beat_i.sample_value),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

endmodule

`default_nettype wire
